FILE: rtl/core/fpc_pkg.sv
// shared widths, codes and constants of the frame pacer
`timescale 1ns / 1ps

package fpc_pkg;

    localparam int TIME_W    = 64;
    localparam int IVL_W     = 32;
    localparam int FPS_W     = 16;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 4;

    localparam logic [TIME_W-1:0] NS_PER_SECOND = TIME_W'(64'd1_000_000_000);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = CFG_IDX_W'(1);

    localparam logic CMD_CHECK   = 1'b0;
    localparam logic CMD_PREPARE = 1'b1;

    typedef enum logic [1:0] {
        ST_WAIT_FRAME   = 2'd0,
        ST_FORCE_FRAME  = 2'd1,
        ST_WAIT_LIMITER = 2'd2,
        ST_PREPARED     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        WK_NONE    = 2'd0,
        WK_TIMED   = 2'd1,
        WK_MESSAGE = 2'd2
    } t_wait_kind;

endpackage

FILE: rtl/core/fpc_srem.sv
// bit-serial restoring remainder of a time value by an interval
`timescale 1ns / 1ps

module fpc_srem import fpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [IVL_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [IVL_W-1:0]  o_rem
);

    localparam int CNT_BITS = $clog2(TIME_W);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(TIME_W - 1);

    logic [TIME_W-1:0]   r_shift;
    logic [IVL_W-1:0]    r_rem;
    logic [IVL_W-1:0]    r_div;
    logic [CNT_BITS-1:0] r_count;
    logic                r_busy;
    logic                r_done;

    logic [IVL_W:0]   w_trial;
    logic [IVL_W:0]   w_diff;
    logic             w_ge;
    logic [IVL_W-1:0] n_rem;

    // one dividend bit per cycle, msb first
    always_comb begin
        w_trial = {r_rem, r_shift[TIME_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = w_trial >= {1'b0, r_div};
        n_rem   = w_ge ? w_diff[IVL_W-1:0] : w_trial[IVL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_shift <= i_dividend;
                r_div   <= i_divisor;
                r_rem   <= '0;
                r_count <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_shift <= {r_shift[TIME_W-2:0], 1'b0};
                r_rem   <= n_rem;
                r_count <= r_count + 1'b1;
                if (r_count == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/frame_pacer_with_fps_counter.sv
// frame pacer: check and prepare events, interval limits and frames-per-second count
// an item passes setup, run, eval and result states; result waits for a free output
// no new item until the result is registered; two 64-step serial remainder units
// the units run in parallel: frame snap or max rounding, and the one-second remainder
// reset: synchronous active low, clears all pacing state, min_interval 0, max all ones
`timescale 1ns / 1ps

module frame_pacer_with_fps_counter import fpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [IVL_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [TIME_W-1:0]    i_now,
    input  logic                 i_wait_for_message,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [1:0]           o_wait_kind,
    output logic [IVL_W-1:0]     o_wait_time,
    output logic [FPS_W-1:0]     o_frames_per_second,
    output logic [TOTAL_W-1:0]   o_frame_total
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_EVAL,
        S_RESULT
    } t_state;

    t_state r_state;

    // configuration
    logic [IVL_W-1:0] r_min_ivl;
    logic [IVL_W-1:0] r_max_ivl;

    // latched item
    logic              r_cmd;
    logic [TIME_W-1:0] r_now;
    logic              r_msg;

    // pacing state
    logic [TIME_W-1:0]  r_frame_start;
    logic               r_frame_started;
    logic [TIME_W-1:0]  r_next_start;
    logic [TIME_W-1:0]  r_second_mark;
    logic               r_mark_valid;
    logic [FPS_W-1:0]   r_fis;
    logic [FPS_W-1:0]   r_fps;
    logic [TOTAL_W-1:0] r_frame_counter;

    // working values
    logic [TIME_W-1:0] r_delta;
    logic [TIME_W-1:0] r_dsec;
    logic [IVL_W-1:0]  r_mx;
    logic              r_below_min;

    // result register
    logic               r_out_valid;
    t_status            r_status;
    t_wait_kind         r_kind;
    logic [IVL_W-1:0]   r_wait;
    logic [FPS_W-1:0]   r_out_fps;
    logic [TOTAL_W-1:0] r_out_total;

    // remainder units
    logic              w_unit_start;
    logic [TIME_W-1:0] w_a_dividend;
    logic [TIME_W-1:0] w_dsec_now;
    logic              w_a_done;
    logic              w_b_done;
    logic [IVL_W-1:0]  w_rem_a;
    logic [IVL_W-1:0]  w_rem_b;

    // decision logic
    logic               w_has_max;
    logic               w_min_set;
    logic               w_in_accept;
    logic               w_out_free;
    logic [IVL_W-1:0]   w_mx;
    logic               w_force;
    logic               w_fps_upd;
    logic               w_publish;
    logic [FPS_W-1:0]   w_fps_after;
    t_status            w_status;
    t_wait_kind         w_kind;
    logic [IVL_W-1:0]   w_wait;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_has_max = (r_max_ivl != '1);
    assign w_min_set = (r_min_ivl != '0);

    // unit a: snap remainder on prepare, max rounding remainder on check
    assign w_unit_start = (r_state == S_SETUP);
    assign w_a_dividend = (r_cmd == CMD_PREPARE) ? (r_next_start - r_frame_start)
                                                 : TIME_W'(r_max_ivl);
    // unit b: time since the second mark, modulo one second
    assign w_dsec_now = r_now - r_second_mark;

    fpc_srem u_rem_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_unit_start),
        .i_dividend (w_a_dividend),
        .i_divisor  (r_min_ivl),
        .o_done     (w_a_done),
        .o_rem      (w_rem_a)
    );

    fpc_srem u_rem_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_unit_start),
        .i_dividend (w_dsec_now),
        .i_divisor  (NS_PER_SECOND[IVL_W-1:0]),
        .o_done     (w_b_done),
        .o_rem      (w_rem_b)
    );

    always_comb begin
        // max rounded down to a multiple of min, only when both are set
        w_mx = (w_has_max && w_min_set) ? (r_max_ivl - w_rem_a) : r_max_ivl;

        w_force   = r_frame_started && w_has_max && (r_delta >= TIME_W'(r_mx));
        w_fps_upd = (r_cmd == CMD_PREPARE) || (r_frame_started && !w_force);
        w_publish = w_fps_upd && (!r_mark_valid || (r_dsec >= NS_PER_SECOND));
        w_fps_after = w_publish ? r_fis : r_fps;

        w_status = ST_WAIT_FRAME;
        w_kind   = WK_NONE;
        w_wait   = '0;
        if (r_cmd == CMD_PREPARE) begin
            w_status = ST_PREPARED;
        end else if (!r_frame_started) begin
            // first frame still pending
            w_kind = r_msg ? WK_MESSAGE : WK_NONE;
        end else if (w_force) begin
            w_status = ST_FORCE_FRAME;
        end else if (r_below_min) begin
            // delta below min, so the difference fits the interval width
            w_status = ST_WAIT_LIMITER;
            w_kind   = WK_TIMED;
            w_wait   = r_min_ivl - r_delta[IVL_W-1:0];
        end else if (r_msg) begin
            if (w_has_max) begin
                w_kind = WK_TIMED;
                w_wait = r_mx - r_delta[IVL_W-1:0];
            end else begin
                w_kind = WK_MESSAGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_min_ivl       <= '0;
            r_max_ivl       <= '1;
            r_frame_start   <= '0;
            r_frame_started <= 1'b0;
            r_next_start    <= '0;
            r_second_mark   <= '0;
            r_mark_valid    <= 1'b0;
            r_fis           <= '0;
            r_fps           <= '0;
            r_frame_counter <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            // configuration port, writes beyond the list are dropped
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MIN_INTERVAL: r_min_ivl <= i_cfg_data;
                    REG_MAX_INTERVAL: r_max_ivl <= i_cfg_data;
                    default: ;
                endcase
            end

            // a result leaving while a new one commits is handled in S_RESULT
            if (r_out_valid && !i_out_stall && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_cmd   <= i_command;
                        r_now   <= i_now;
                        r_msg   <= i_wait_for_message;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_delta <= r_now - r_frame_start;
                    r_dsec  <= w_dsec_now;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_a_done && w_b_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_mx        <= w_mx;
                    r_below_min <= (r_delta < TIME_W'(r_min_ivl));
                    if (r_cmd == CMD_PREPARE) begin
                        // snap the start back to a whole number of min intervals
                        r_frame_start   <= w_min_set ? (r_next_start - TIME_W'(w_rem_a))
                                                     : r_next_start;
                        r_frame_started <= 1'b1;
                        if (r_fis != '1) begin
                            r_fis <= r_fis + 1'b1;
                        end
                        r_frame_counter <= r_frame_counter + 1'b1;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    // state and result commit together once the output is free
                    if (w_out_free) begin
                        if (r_cmd == CMD_CHECK) begin
                            r_next_start <= r_now;
                        end
                        if (w_publish) begin
                            r_second_mark <= r_mark_valid ? (r_now - TIME_W'(w_rem_b)) : r_now;
                            r_mark_valid  <= 1'b1;
                            r_fps         <= r_fis;
                            r_fis         <= '0;
                        end
                        r_status    <= w_status;
                        r_kind      <= w_kind;
                        r_wait      <= w_wait;
                        r_out_fps   <= w_fps_after;
                        r_out_total <= r_frame_counter;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_wait_kind         = r_kind;
    assign o_wait_time         = r_wait;
    assign o_frames_per_second = r_out_fps;
    assign o_frame_total       = r_out_total;

`ifndef ASSERT_OFF
    // both remainder units run in lockstep
    a_units_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_a_done == w_b_done)
        else $error("remainder units out of step");

    // once a frame has started it stays started
    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_started |=> r_frame_started)
        else $error("frame started flag dropped");

    // the per-second count saturates or is cleared, never wraps
    a_fis_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fis == '1) |=> ((r_fis == '1) || (r_fis == '0)))
        else $error("frames in second wrapped");

    // a limiter wait is always a timed wait of nonzero length
    a_limiter_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_WAIT_LIMITER))
            |-> ((r_kind == WK_TIMED) && (r_wait != '0)))
        else $error("limiter result without timed wait");

    // no wait time unless the wait is timed
    a_wait_only_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind != WK_TIMED)) |-> (r_wait == '0))
        else $error("wait time on untimed result");
`endif

endmodule

FILE: test/frame_pacer_with_fps_counter_test.sv
// testbench of the frame pacer: directed and random check and prepare items, checked by a predictor
`timescale 1ns / 1ps

module frame_pacer_with_fps_counter_test;
    import fpc_pkg::*;

    localparam int CLK_HALF_NS = 2;
    localparam int RESET_CYCLES = 10;
    localparam int HOLD_CYCLES = 600;      // long receiver hold-off, fills the block
    localparam int SETTLE_CYCLES = 80;     // a bit more than the block's latency
    localparam int LIMIT_NS = 10_000_000;
    localparam int PRINT_MAX = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);
    localparam logic [IVL_W-1:0] NO_LIMIT = '1;

    // one result item as the block reports it
    typedef struct packed {
        t_status             status;
        t_wait_kind          wait_kind;
        logic [IVL_W-1:0]    wait_time;
        logic [FPS_W-1:0]    fps;
        logic [TOTAL_W-1:0]  total;
    } t_pacer_result;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [IVL_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_command = CMD_CHECK;
    logic [TIME_W-1:0]    i_now = '0;
    logic                 i_wait_for_message = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic [1:0]           o_wait_kind;
    logic [IVL_W-1:0]     o_wait_time;
    logic [FPS_W-1:0]     o_frames_per_second;
    logic [TOTAL_W-1:0]   o_frame_total;

    frame_pacer_with_fps_counter uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_command           (i_command),
        .i_now               (i_now),
        .i_wait_for_message  (i_wait_for_message),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_wait_kind         (o_wait_kind),
        .o_wait_time         (o_wait_time),
        .o_frames_per_second (o_frames_per_second),
        .o_frame_total       (o_frame_total)
    );

    // pacing answers still owed by the block, oldest first
    t_pacer_result pacing_answers[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_active = 1'b0;
    event hold_go;

    // predictor copy of registers and pacing state
    logic [IVL_W-1:0]   cfg_min;
    logic [IVL_W-1:0]   cfg_max;
    logic [TIME_W-1:0]  cur_frame_start;
    logic               have_frame;
    logic [TIME_W-1:0]  cand_start;
    logic [TIME_W-1:0]  sec_mark;
    logic               sec_mark_ok;
    logic [FPS_W-1:0]   sec_frames;
    logic [FPS_W-1:0]   pub_fps;
    logic [TOTAL_W-1:0] frames_done;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #LIMIT_NS;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_pacing();
        cfg_min = '0;
        cfg_max = NO_LIMIT;
        cur_frame_start = '0;
        have_frame = 1'b0;
        cand_start = '0;
        sec_mark = '0;
        sec_mark_ok = 1'b0;
        sec_frames = '0;
        pub_fps = '0;
        frames_done = '0;
    endfunction

    function automatic logic max_active();
        return cfg_max != NO_LIMIT;
    endfunction

    // max interval rounded down to whole min intervals
    function automatic logic [TIME_W-1:0] max_span();
        if (max_active() && cfg_min != '0)
            return TIME_W'(cfg_max / cfg_min) * TIME_W'(cfg_min);
        return TIME_W'(cfg_max);
    endfunction

    // publish the count once per elapsed second, mark moves by whole seconds
    function automatic void tally_second(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] d;
        if (!sec_mark_ok) begin
            sec_mark = t;
            sec_mark_ok = 1'b1;
            pub_fps = sec_frames;
            sec_frames = '0;
        end else begin
            d = t - sec_mark;
            if (d >= NS_PER_SECOND) begin
                sec_mark = t - d % NS_PER_SECOND;
                pub_fps = sec_frames;
                sec_frames = '0;
            end
        end
    endfunction

    function automatic t_pacer_result predict_pacing(input logic cmd,
                                                     input logic [TIME_W-1:0] now,
                                                     input logic msg);
        t_pacer_result r;
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] mx;
        r.status = ST_WAIT_FRAME;
        r.wait_kind = WK_NONE;
        r.wait_time = '0;
        if (cmd == CMD_CHECK) begin
            cand_start = now;
            if (!have_frame) begin
                if (msg) r.wait_kind = WK_MESSAGE;
            end else begin
                delta = now - cur_frame_start;
                mx = max_span();
                if (max_active() && delta >= mx) begin
                    r.status = ST_FORCE_FRAME;
                end else begin
                    tally_second(now);
                    if (delta < TIME_W'(cfg_min)) begin
                        r.status = ST_WAIT_LIMITER;
                        r.wait_kind = WK_TIMED;
                        r.wait_time = IVL_W'(TIME_W'(cfg_min) - delta);
                    end else if (msg) begin
                        if (max_active()) begin
                            r.wait_kind = WK_TIMED;
                            r.wait_time = IVL_W'(mx - delta);
                        end else begin
                            r.wait_kind = WK_MESSAGE;
                        end
                    end
                end
            end
        end else begin
            // snap the new start back onto the min interval grid
            if (cfg_min != '0)
                cur_frame_start = cand_start - (cand_start - cur_frame_start) % TIME_W'(cfg_min);
            else
                cur_frame_start = cand_start;
            have_frame = 1'b1;
            if (sec_frames != '1) sec_frames = sec_frames + 1'b1;
            frames_done = frames_done + 1'b1;
            tally_second(now);
            r.status = ST_PREPARED;
        end
        r.fps = pub_fps;
        r.total = frames_done;
        return r;
    endfunction

    // ---------------------------------------------------------------- result side

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // receiver stall: random, or held high during a hold-off
    always @(posedge i_clk) begin
        i_out_stall <= hold_active || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // hold-off length counted here, in cycles
    always begin
        @(hold_go);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    always @(posedge i_clk) begin : check_results
        t_pacer_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pacing_answers.size() == 0) begin
                report_mismatch("result with nothing pending, status", 64'(o_status), 64'(0));
            end else begin
                want = pacing_answers.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_wait_kind !== want.wait_kind)
                    report_mismatch("wait_kind", 64'(o_wait_kind), 64'(want.wait_kind));
                if (o_wait_time !== want.wait_time)
                    report_mismatch("wait_time", 64'(o_wait_time), 64'(want.wait_time));
                if (o_frames_per_second !== want.fps)
                    report_mismatch("frames_per_second", 64'(o_frames_per_second),
                                    64'(want.fps));
                if (o_frame_total !== want.total)
                    report_mismatch("frame_total", 64'(o_frame_total), 64'(want.total));
            end
        end
    end

    // ---------------------------------------------------------------- send side

    // offer one item, hold it through stalls, predict on acceptance
    task automatic send_event(input logic cmd, input logic [TIME_W-1:0] now, input logic msg,
                              output t_pacer_result res);
        int gap;
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, 90);   // occasional long gap, lands mid-computation
        else
            while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_now <= now;
        i_wait_for_message <= msg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = predict_pacing(cmd, now, msg);
        pacing_answers.push_back(res);
    endtask

    // drop valid and let every owed result come back
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pacing_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IVL_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == REG_MIN_INTERVAL) cfg_min = data;
        else if (idx == REG_MAX_INTERVAL) cfg_max = data;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [IVL_W-1:0] min_ns, input logic [IVL_W-1:0] max_ns);
        write_reg(REG_MIN_INTERVAL, min_ns);
        write_reg(REG_MAX_INTERVAL, max_ns);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // render loop: checks at advancing times, a prepare once a frame is due,
    // mixed with some noise (random times, time going back, stray prepares)
    task automatic run_frame_loop(input int n_items);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] step;
        logic [IVL_W-1:0] s;
        t_pacer_result r;
        int k;
        s = (cfg_min != '0) ? cfg_min : (max_active() ? cfg_max : 32'd16_666_667);
        t = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : TIME_W'($urandom);
        k = 0;
        while (k < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 2))
                    0: send_event(1'($urandom_range(0, 1)), {$urandom, $urandom},
                                  1'($urandom_range(0, 1)), r);
                    1: send_event(CMD_CHECK, t - TIME_W'($urandom_range(1, 1000)),
                                  1'($urandom_range(0, 1)), r);
                    default: send_event(CMD_PREPARE, t, 1'($urandom_range(0, 1)), r);
                endcase
                k++;
            end else begin
                step = TIME_W'($urandom_range(0, s)) + TIME_W'($urandom_range(0, s));
                if ($urandom_range(0, 9) == 0) step = step * 3;
                t = t + step;
                send_event(CMD_CHECK, t, 1'($urandom_range(0, 1)), r);
                k++;
                if (r.status == ST_FORCE_FRAME ||
                    (r.status == ST_WAIT_FRAME && $urandom_range(0, 2) != 0)) begin
                    t = t + TIME_W'($urandom_range(0, s / 8));
                    send_event(CMD_PREPARE, t, 1'($urandom_range(0, 1)), r);
                    k++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // reset limits: first-frame waits, prepares reusing a held start, message-only wait
    task automatic test_first_frame();
        t_pacer_result r;
        send_event(CMD_CHECK, '0, 1'b0, r);
        send_event(CMD_CHECK, '1, 1'b1, r);
        send_event(CMD_PREPARE, '1, 1'b0, r);
        send_event(CMD_PREPARE, 64'd10, 1'b1, r);
        send_event(CMD_CHECK, 64'd20, 1'b1, r);
        wait_results();
    endtask

    // frame cap with no max: limiter wait inside the interval, message wait after it
    task automatic test_limiter();
        t_pacer_result r;
        set_limits(32'd16_666_667, NO_LIMIT);
        send_event(CMD_CHECK, 64'd3_000_000_000, 1'b0, r);
        send_event(CMD_PREPARE, 64'd3_000_001_000, 1'b0, r);
        send_event(CMD_CHECK, 64'd3_000_000_000, 1'b1, r);
        send_event(CMD_CHECK, 64'd3_040_000_000, 1'b1, r);
        wait_results();
    endtask

    // max only: timed wait up to the max, forced frame past it, then max of one
    task automatic test_max_interval();
        t_pacer_result r;
        set_limits('0, 32'd50_000_000);
        send_event(CMD_CHECK, 64'd7_000_000_000, 1'b0, r);
        send_event(CMD_PREPARE, 64'd7_000_000_000, 1'b0, r);
        send_event(CMD_CHECK, 64'd7_010_000_000, 1'b1, r);
        send_event(CMD_CHECK, 64'd7_060_000_000, 1'b0, r);
        wait_results();
        set_limits('0, 32'd1);
        send_event(CMD_CHECK, 64'd7_000_000_000, 1'b1, r);
        send_event(CMD_CHECK, 64'd7_000_000_005, 1'b0, r);
        wait_results();
    endtask

    // min above max rounds the max to zero: every check forces
    task automatic test_min_above_max();
        t_pacer_result r;
        set_limits('1, 32'd1000);
        send_event(CMD_PREPARE, 64'd9_000_000_000, 1'b0, r);
        send_event(CMD_CHECK, 64'd9_000_000_001, 1'b0, r);
        send_event(CMD_CHECK, 64'd9_000_000_000, 1'b1, r);
        wait_results();
    endtask

    // an earlier time wraps into a huge interval
    task automatic test_time_backwards();
        t_pacer_result r;
        set_limits(32'd1_000_000, 32'hFFFF_FFFE);
        send_event(CMD_CHECK, 64'd12_000_000_000, 1'b0, r);
        send_event(CMD_PREPARE, 64'd12_000_000_000, 1'b0, r);
        send_event(CMD_CHECK, 64'd11_999_999_995, 1'b1, r);
        wait_results();
    endtask

    // a write beyond the last register changes nothing
    task automatic test_unused_register();
        t_pacer_result r;
        write_reg(REG_UNUSED, '1);
        send_event(CMD_CHECK, 64'd12_000_500_000, 1'b1, r);
        wait_results();
    endtask

    // long random render loops over several limit settings and idling patterns
    task automatic test_random_pacing();
        set_idling(29, 83);
        set_limits(32'd16_666_667, NO_LIMIT);
        run_frame_loop(170);
        wait_results();
        set_limits(32'd8_333_333, 32'd100_000_000);
        run_frame_loop(170);
        wait_results();
        set_idling(83, 29);
        set_limits('0, 32'd50_000_000);
        run_frame_loop(170);
        wait_results();
        set_limits('0, NO_LIMIT);
        run_frame_loop(170);
        wait_results();
        set_idling(0, 0);
        set_limits($urandom_range(40_000_000, 1), $urandom_range(32'hFFFF_FFFF, 1));
        run_frame_loop(80);
        wait_results();
        set_limits('1, '1);
        run_frame_loop(100);
        wait_results();
        set_limits(32'd10_000_000, 32'd5_000_000);
        run_frame_loop(30);
        wait_results();
    endtask

    // receiver holds off while items keep coming, then the sender pauses for a drain
    task automatic test_backpressure();
        set_idling(0, 0);
        set_limits(32'd1_000_000, 32'd40_000_000);
        -> hold_go;
        run_frame_loop(12);
        wait_results();
        run_frame_loop(8);
        wait_results();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_pacing();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(29, 83);
        test_first_frame();
        test_limiter();
        test_max_interval();
        test_min_above_max();
        test_time_backwards();
        test_unused_register();
        test_random_pacing();
        test_backpressure();

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pacing_answers.size() != 0)
            report_mismatch("results never delivered", 64'(pacing_answers.size()), 64'(0));
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
